/* rtl/core/ptq_pkg.sv */
// shared types, constants and helpers for the primitive to quad transform
package ptq_pkg;

  localparam int CoordW  = 32;
  localparam int HwW     = 31;
  localparam int MagW    = CoordW + 1;
  localparam int NormW   = 31;
  localparam int ShW     = $clog2(NormW);
  localparam int RadW    = 2 * NormW + 1;
  localparam int RootW   = 32;
  localparam int QuotW   = 31;
  localparam int ScaleW  = 24;
  localparam int CfgIdxW = 3;
  localparam int ColorW  = 32;
  localparam int SprW    = 16;

  localparam logic [ScaleW-1:0] ScaleReset = ScaleW'(65536);

  typedef logic signed [CoordW-1:0] coord_t;

  typedef enum logic [1:0] {
    ACT_QUAD   = 2'd0,
    ACT_SPRITE = 2'd1,
    ACT_RECT   = 2'd2,
    ACT_LINE   = 2'd3
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PIVOT_X  = 3'd0,
    CFG_PIVOT_Y  = 3'd1,
    CFG_SCALE    = 3'd2,
    CFG_OFFSET_X = 3'd3,
    CFG_OFFSET_Y = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]        action;
    coord_t            p0_x;
    coord_t            p0_y;
    coord_t            p1_x;
    coord_t            p1_y;
    coord_t            p2_x;
    coord_t            p2_y;
    coord_t            p3_x;
    coord_t            p3_y;
    logic [HwW-1:0]    half_width;
    logic [ColorW-1:0] color;
    logic [SprW-1:0]   sprite_index;
  } prim_t;

  typedef struct packed {
    coord_t            out0_x;
    coord_t            out0_y;
    coord_t            out1_x;
    coord_t            out1_y;
    coord_t            out2_x;
    coord_t            out2_y;
    coord_t            out3_x;
    coord_t            out3_y;
    logic [ColorW-1:0] out_color;
    logic [SprW-1:0]   out_sprite;
  } quad_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [31:0]        value;
  } cfg_t;

  typedef struct packed {
    coord_t [3:0]      cx;
    coord_t [3:0]      cy;
    coord_t            ax;
    coord_t            ay;
    coord_t            bx;
    coord_t            by;
    logic [HwW-1:0]    hw;
    logic              dy_pos;
    logic              dx_neg;
    logic              line_nd;
    logic [ColorW-1:0] color;
    logic [SprW-1:0]   sprite;
  } side_t;

  typedef struct packed {
    side_t            side;
    logic [NormW-1:0] nx;
    logic [NormW-1:0] ny;
  } norm_t;

  function automatic coord_t sat32(input logic signed [63:0] v);
    coord_t r;
    if (v > 64'sd2147483647) begin
      r = coord_t'(32'h7FFF_FFFF);
    end else if (v < -64'sd2147483648) begin
      r = coord_t'(32'h8000_0000);
    end else begin
      r = coord_t'(v[CoordW-1:0]);
    end
    return r;
  endfunction

endpackage

/* rtl/core/ptq_if.sv */
// valid/ready channel interfaces for primitives, quads and config writes
interface ptq_prim_if import ptq_pkg::*; ();
  logic  valid;
  logic  ready;
  prim_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface ptq_quad_if import ptq_pkg::*; ();
  logic  valid;
  logic  ready;
  quad_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface ptq_cfg_if import ptq_pkg::*; ();
  logic valid;
  logic ready;
  cfg_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* rtl/core/ptq_front.sv */
// corner building, line delta normalization and sum of squares, five stages
module ptq_front
  import ptq_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  prim_t            prim_i,
  output logic             valid_o,
  output norm_t            norm_o,
  output logic [RadW-1:0]  rad_o
);

  logic signed [63:0] ax, ay, bx, by, hw, dx, dy;
  coord_t             axbx, ayby;
  side_t              s1_d;
  logic [MagW-1:0]    mx_d, my_d;

  always_comb begin
    ax   = 64'(prim_i.p0_x);
    ay   = 64'(prim_i.p0_y);
    bx   = 64'(prim_i.p1_x);
    by   = 64'(prim_i.p1_y);
    hw   = $signed(64'(prim_i.half_width));
    dx   = bx - ax;
    dy   = by - ay;
    axbx = sat32(ax + bx);
    ayby = sat32(ay + by);
    mx_d = (dx < 64'sd0) ? MagW'(-dx) : MagW'(dx);
    my_d = (dy < 64'sd0) ? MagW'(-dy) : MagW'(dy);
    s1_d         = '0;
    s1_d.ax      = prim_i.p0_x;
    s1_d.ay      = prim_i.p0_y;
    s1_d.bx      = prim_i.p1_x;
    s1_d.by      = prim_i.p1_y;
    s1_d.hw      = prim_i.half_width;
    s1_d.dy_pos  = dy > 64'sd0;
    s1_d.dx_neg  = dx < 64'sd0;
    s1_d.color   = prim_i.color;
    s1_d.sprite  = prim_i.sprite_index;
    s1_d.line_nd = 1'b0;
    unique case (action_e'(prim_i.action))
      ACT_QUAD: begin
        s1_d.cx[0] = prim_i.p0_x; s1_d.cy[0] = prim_i.p0_y;
        s1_d.cx[1] = prim_i.p1_x; s1_d.cy[1] = prim_i.p1_y;
        s1_d.cx[2] = prim_i.p2_x; s1_d.cy[2] = prim_i.p2_y;
        s1_d.cx[3] = prim_i.p3_x; s1_d.cy[3] = prim_i.p3_y;
      end
      ACT_SPRITE: begin
        s1_d.cx[0] = prim_i.p0_x; s1_d.cy[0] = prim_i.p0_y;
        s1_d.cx[1] = prim_i.p0_x; s1_d.cy[1] = ayby;
        s1_d.cx[2] = axbx;        s1_d.cy[2] = ayby;
        s1_d.cx[3] = axbx;        s1_d.cy[3] = prim_i.p0_y;
      end
      ACT_RECT: begin
        s1_d.cx[0] = prim_i.p0_x; s1_d.cy[0] = ayby;
        s1_d.cx[1] = axbx;        s1_d.cy[1] = ayby;
        s1_d.cx[2] = axbx;        s1_d.cy[2] = prim_i.p0_y;
        s1_d.cx[3] = prim_i.p0_x; s1_d.cy[3] = prim_i.p0_y;
      end
      ACT_LINE: begin
        s1_d.sprite  = '0;
        s1_d.line_nd = (dx != 64'sd0) || (dy != 64'sd0);
        s1_d.cx[0] = sat32(ax - hw); s1_d.cy[0] = sat32(ay + hw);
        s1_d.cx[1] = sat32(ax + hw); s1_d.cy[1] = sat32(ay + hw);
        s1_d.cx[2] = sat32(ax + hw); s1_d.cy[2] = sat32(ay - hw);
        s1_d.cx[3] = sat32(ax - hw); s1_d.cy[3] = sat32(ay - hw);
      end
    endcase
  end

  logic             v1_q, v2_q, v3_q, v4_q, v5_q;
  side_t            s1_q, s2_q, s3_q, s4_q;
  logic [MagW-1:0]  mx1_q, my1_q, mx2_q, my2_q;
  logic [1:0]       rs_d, rs_q;
  logic [ShW-1:0]   ls_d, ls_q, msb;
  logic [MagW-1:0]  mm;
  logic [NormW-1:0] nx_d, ny_d, nx3_q, ny3_q, nx4_q, ny4_q;
  logic [2*NormW-1:0] sqx_d, sqy_d, sqx_q, sqy_q;
  logic [RadW-1:0]  sum_d, sum_q;
  norm_t            n5_q;

  // shift that brings the larger magnitude into [2^30, 2^31)
  always_comb begin
    mm  = (mx1_q > my1_q) ? mx1_q : my1_q;
    msb = '0;
    for (int i = 0; i < NormW; i++) begin
      if (mm[i]) msb = ShW'(i);
    end
    if (mm[MagW-1]) begin
      rs_d = 2'd2;
    end else if (mm[MagW-2]) begin
      rs_d = 2'd1;
    end else begin
      rs_d = 2'd0;
    end
    ls_d = ShW'(NormW - 1) - msb;
  end

  always_comb begin
    nx_d  = (rs_q != 2'd0) ? NormW'(mx2_q >> rs_q) : NormW'(mx2_q << ls_q);
    ny_d  = (rs_q != 2'd0) ? NormW'(my2_q >> rs_q) : NormW'(my2_q << ls_q);
    sqx_d = (2*NormW)'(nx3_q) * (2*NormW)'(nx3_q);
    sqy_d = (2*NormW)'(ny3_q) * (2*NormW)'(ny3_q);
    sum_d = RadW'(sqx_q) + RadW'(sqy_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q  <= s1_d;
      mx1_q <= mx_d;
      my1_q <= my_d;
      s2_q  <= s1_q;
      mx2_q <= mx1_q;
      my2_q <= my1_q;
      rs_q  <= rs_d;
      ls_q  <= ls_d;
      s3_q  <= s2_q;
      nx3_q <= nx_d;
      ny3_q <= ny_d;
      s4_q  <= s3_q;
      nx4_q <= nx3_q;
      ny4_q <= ny3_q;
      sqx_q <= sqx_d;
      sqy_q <= sqy_d;
      n5_q  <= '{side: s4_q, nx: nx4_q, ny: ny4_q};
      sum_q <= sum_d;
    end
  end

  assign valid_o = v5_q;
  assign norm_o  = n5_q;
  assign rad_o   = sum_q;

endmodule

/* rtl/core/ptq_sqrt.sv */
// pipelined integer square root, one result bit per stage
module ptq_sqrt
  import ptq_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  norm_t            norm_i,
  input  logic [RadW-1:0]  rad_i,
  output logic             valid_o,
  output norm_t            norm_o,
  output logic [RootW-1:0] root_o
);

  localparam int TrialW = 2 * RootW + 2;

  logic             v_a    [RootW+1];
  norm_t            norm_a [RootW+1];
  logic [RadW-1:0]  rem_a  [RootW+1];
  logic [RootW-1:0] root_a [RootW+1];

  assign v_a[0]    = valid_i;
  assign norm_a[0] = norm_i;
  assign rem_a[0]  = rad_i;
  assign root_a[0] = '0;

  for (genvar s = 0; s < RootW; s++) begin : g_stage
    localparam int Bit = RootW - 1 - s;
    logic [TrialW-1:0] trial;
    logic              take;
    logic              v_q;
    norm_t             norm_q;
    logic [RadW-1:0]   rem_q;
    logic [RootW-1:0]  root_q;

    assign trial = (TrialW'(root_a[s]) << (Bit + 1)) + (TrialW'(1) << (2 * Bit));
    assign take  = TrialW'(rem_a[s]) >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= v_a[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        norm_q <= norm_a[s];
        rem_q  <= take ? RadW'(TrialW'(rem_a[s]) - trial) : rem_a[s];
        root_q <= take ? (root_a[s] | (RootW'(1) << Bit)) : root_a[s];
      end
    end

    assign v_a[s+1]    = v_q;
    assign norm_a[s+1] = norm_q;
    assign rem_a[s+1]  = rem_q;
    assign root_a[s+1] = root_q;
  end

  assign valid_o = v_a[RootW];
  assign norm_o  = norm_a[RootW];
  assign root_o  = root_a[RootW];

endmodule

/* rtl/core/ptq_div.sv */
// perpendicular magnitudes: products, rounding and two-lane restoring divide
module ptq_div
  import ptq_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  norm_t            norm_i,
  input  logic [RootW-1:0] len_i,
  output logic             valid_o,
  output side_t            side_o,
  output logic [QuotW-1:0] mpx_o,
  output logic [QuotW-1:0] mpy_o
);

  localparam int ProdW = NormW + HwW;
  localparam int NumW  = ProdW + 1;
  localparam int DivW  = NumW + 1;

  logic               vp_q, vn_q;
  side_t              sp_q, sn_q;
  logic [RootW-1:0]   lp_q, ln_q;
  logic [ProdW-1:0]   pa_q, pb_q;
  logic [NumW-1:0]    na_q, nb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
      vn_q <= 1'b0;
    end else if (en_i) begin
      vp_q <= valid_i;
      vn_q <= vp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sp_q <= norm_i.side;
      lp_q <= len_i;
      pa_q <= ProdW'(norm_i.ny) * ProdW'(norm_i.side.hw);
      pb_q <= ProdW'(norm_i.nx) * ProdW'(norm_i.side.hw);
      sn_q <= sp_q;
      ln_q <= lp_q;
      na_q <= NumW'(pa_q) + NumW'(lp_q >> 1);
      nb_q <= NumW'(pb_q) + NumW'(lp_q >> 1);
    end
  end

  logic             v_a    [QuotW+1];
  side_t            side_a [QuotW+1];
  logic [RootW-1:0] len_a  [QuotW+1];
  logic [NumW-1:0]  ra_a   [QuotW+1];
  logic [NumW-1:0]  rb_a   [QuotW+1];
  logic [QuotW-1:0] qa_a   [QuotW+1];
  logic [QuotW-1:0] qb_a   [QuotW+1];

  assign v_a[0]    = vn_q;
  assign side_a[0] = sn_q;
  assign len_a[0]  = ln_q;
  assign ra_a[0]   = na_q;
  assign rb_a[0]   = nb_q;
  assign qa_a[0]   = '0;
  assign qb_a[0]   = '0;

  for (genvar s = 0; s < QuotW; s++) begin : g_stage
    localparam int Bit = QuotW - 1 - s;
    logic [DivW-1:0]  dsh;
    logic             take_a, take_b;
    logic             v_q;
    side_t            side_q;
    logic [RootW-1:0] len_q;
    logic [NumW-1:0]  ra_q, rb_q;
    logic [QuotW-1:0] qa_q, qb_q;

    assign dsh    = DivW'(len_a[s]) << Bit;
    assign take_a = DivW'(ra_a[s]) >= dsh;
    assign take_b = DivW'(rb_a[s]) >= dsh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= v_a[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q <= side_a[s];
        len_q  <= len_a[s];
        ra_q   <= take_a ? NumW'(DivW'(ra_a[s]) - dsh) : ra_a[s];
        rb_q   <= take_b ? NumW'(DivW'(rb_a[s]) - dsh) : rb_a[s];
        qa_q   <= take_a ? (qa_a[s] | (QuotW'(1) << Bit)) : qa_a[s];
        qb_q   <= take_b ? (qb_a[s] | (QuotW'(1) << Bit)) : qb_a[s];
      end
    end

    assign v_a[s+1]    = v_q;
    assign side_a[s+1] = side_q;
    assign len_a[s+1]  = len_q;
    assign ra_a[s+1]   = ra_q;
    assign rb_a[s+1]   = rb_q;
    assign qa_a[s+1]   = qa_q;
    assign qb_a[s+1]   = qb_q;
  end

  assign valid_o = v_a[QuotW];
  assign side_o  = side_a[QuotW];
  assign mpx_o   = qa_a[QuotW];
  assign mpy_o   = qb_a[QuotW];

endmodule

/* rtl/core/ptq_xform.sv */
// line corner select, then scale about pivot and offset with saturation
module ptq_xform
  import ptq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  side_t             side_i,
  input  logic [QuotW-1:0]  mpx_i,
  input  logic [QuotW-1:0]  mpy_i,
  input  coord_t            pivot_x_i,
  input  coord_t            pivot_y_i,
  input  logic [ScaleW-1:0] scale_i,
  input  coord_t            offset_x_i,
  input  coord_t            offset_y_i,
  output logic              valid_o,
  output quad_t             quad_o
);

  localparam int DiffW = CoordW + 1;
  localparam int ProdW = DiffW + ScaleW + 1;

  logic signed [63:0] px, py, ax, ay, bx, by;
  coord_t [3:0]       hx_d, hy_d, hx_q, hy_q;

  always_comb begin
    px = $signed(64'(mpx_i));
    py = $signed(64'(mpy_i));
    if (side_i.dy_pos) px = -px;
    if (side_i.dx_neg) py = -py;
    ax = 64'(side_i.ax);
    ay = 64'(side_i.ay);
    bx = 64'(side_i.bx);
    by = 64'(side_i.by);
    hx_d = side_i.cx;
    hy_d = side_i.cy;
    if (side_i.line_nd) begin
      hx_d[0] = sat32(ax + px); hy_d[0] = sat32(ay + py);
      hx_d[1] = sat32(bx + px); hy_d[1] = sat32(by + py);
      hx_d[2] = sat32(bx - px); hy_d[2] = sat32(by - py);
      hx_d[3] = sat32(ax - px); hy_d[3] = sat32(ay - py);
    end
  end

  logic                    vh_q, vd_q, vp_q, vo_q;
  logic [ColorW-1:0]       ch_q, cd_q, cp_q;
  logic [SprW-1:0]         sh_q, sd_q, sp_q;
  logic signed [DiffW-1:0] dx_d [4];
  logic signed [DiffW-1:0] dy_d [4];
  logic signed [DiffW-1:0] dx_q [4];
  logic signed [DiffW-1:0] dy_q [4];
  logic signed [ProdW-1:0] mx_d [4];
  logic signed [ProdW-1:0] my_d [4];
  logic signed [ProdW-1:0] mx_q [4];
  logic signed [ProdW-1:0] my_q [4];
  coord_t                  rx_d [4];
  coord_t                  ry_d [4];
  quad_t                   quad_q;

  always_comb begin
    logic signed [63:0] tx, ty;
    logic signed [ProdW-1:0] sc;
    sc = ProdW'($signed({1'b0, scale_i}));
    for (int k = 0; k < 4; k++) begin
      dx_d[k] = DiffW'($signed(hx_q[k])) - DiffW'(pivot_x_i);
      dy_d[k] = DiffW'($signed(hy_q[k])) - DiffW'(pivot_y_i);
      mx_d[k] = ProdW'(dx_q[k]) * sc;
      my_d[k] = ProdW'(dy_q[k]) * sc;
      tx = (64'(mx_q[k]) + 64'sd32768) >>> 16;
      ty = (64'(my_q[k]) + 64'sd32768) >>> 16;
      rx_d[k] = sat32(tx + 64'(pivot_x_i) + 64'(offset_x_i));
      ry_d[k] = sat32(ty + 64'(pivot_y_i) + 64'(offset_y_i));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vh_q <= 1'b0;
      vd_q <= 1'b0;
      vp_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en_i) begin
      vh_q <= valid_i;
      vd_q <= vh_q;
      vp_q <= vd_q;
      vo_q <= vp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hx_q <= hx_d;
      hy_q <= hy_d;
      ch_q <= side_i.color;
      sh_q <= side_i.sprite;
      cd_q <= ch_q;
      sd_q <= sh_q;
      cp_q <= cd_q;
      sp_q <= sd_q;
      for (int k = 0; k < 4; k++) begin
        dx_q[k] <= dx_d[k];
        dy_q[k] <= dy_d[k];
        mx_q[k] <= mx_d[k];
        my_q[k] <= my_d[k];
      end
      quad_q <= '{out0_x: rx_d[0], out0_y: ry_d[0],
                  out1_x: rx_d[1], out1_y: ry_d[1],
                  out2_x: rx_d[2], out2_y: ry_d[2],
                  out3_x: rx_d[3], out3_y: ry_d[3],
                  out_color: cp_q, out_sprite: sp_q};
    end
  end

  assign valid_o = vo_q;
  assign quad_o  = quad_q;

endmodule

/* rtl/core/primitive_to_quad_transform.sv */
// top level: draw primitive to transformed quad pipeline
//
//   channel  dir  word    accepted when
//   prim_i   in   prim_t  prim_i.valid & prim_i.ready
//   quad_o   out  quad_t  quad_o.valid & quad_o.ready
//   cfg_i    in   cfg_t   cfg_i.valid (ready is always high)
//
// one primitive per cycle unless the output stalls, through these stages:
// 5 front stages, 32 square root stages, 33 divide stages, 4 transform stages.
// every kind of primitive takes the same path, so words leave in order.
// one shared enable moves all stages; it drops only while a finished quad
// waits in the output register, which then holds until taken.
// reset clears valid bits and loads register defaults (scale 1.0).
module primitive_to_quad_transform
  import ptq_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  ptq_prim_if.sink        prim_i,
  ptq_quad_if.source      quad_o,
  ptq_cfg_if.sink         cfg_i
);

  coord_t            pivot_x_q, pivot_y_q, offset_x_q, offset_y_q;
  logic [ScaleW-1:0] scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pivot_x_q  <= '0;
      pivot_y_q  <= '0;
      scale_q    <= ScaleReset;
      offset_x_q <= '0;
      offset_y_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.data.index))
        CFG_PIVOT_X:  pivot_x_q  <= coord_t'(cfg_i.data.value);
        CFG_PIVOT_Y:  pivot_y_q  <= coord_t'(cfg_i.data.value);
        CFG_SCALE:    scale_q    <= cfg_i.data.value[ScaleW-1:0];
        CFG_OFFSET_X: offset_x_q <= coord_t'(cfg_i.data.value);
        CFG_OFFSET_Y: offset_y_q <= coord_t'(cfg_i.data.value);
        default: ;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;

  logic en;
  logic out_valid;

  assign en           = ~out_valid | quad_o.ready;
  assign prim_i.ready = en;
  assign quad_o.valid = out_valid;

  logic             fr_valid, sq_valid, dv_valid;
  norm_t            fr_norm, sq_norm;
  logic [RadW-1:0]  fr_rad;
  logic [RootW-1:0] sq_root;
  side_t            dv_side;
  logic [QuotW-1:0] dv_mpx, dv_mpy;

  ptq_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (prim_i.valid),
    .prim_i  (prim_i.data),
    .valid_o (fr_valid),
    .norm_o  (fr_norm),
    .rad_o   (fr_rad)
  );

  ptq_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .norm_i  (fr_norm),
    .rad_i   (fr_rad),
    .valid_o (sq_valid),
    .norm_o  (sq_norm),
    .root_o  (sq_root)
  );

  ptq_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .norm_i  (sq_norm),
    .len_i   (sq_root),
    .valid_o (dv_valid),
    .side_o  (dv_side),
    .mpx_o   (dv_mpx),
    .mpy_o   (dv_mpy)
  );

  ptq_xform u_xform (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (dv_valid),
    .side_i     (dv_side),
    .mpx_i      (dv_mpx),
    .mpy_i      (dv_mpy),
    .pivot_x_i  (pivot_x_q),
    .pivot_y_i  (pivot_y_q),
    .scale_i    (scale_q),
    .offset_x_i (offset_x_q),
    .offset_y_i (offset_y_q),
    .valid_o    (out_valid),
    .quad_o     (quad_o.data)
  );

endmodule

/* bench/tb.sv */
// self-checking bench for the primitive to quad transform: random and directed words, scoreboard
module tb;
  import ptq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  class quad_scoreboard;
    quad_t     pending[$];
    longint    pivot_x, pivot_y, scale, offset_x, offset_y;
    int        errors;
    int        checked;
    int        kind_seen[4];

    function new();
      pivot_x = 0;
      pivot_y = 0;
      scale = 65536;
      offset_x = 0;
      offset_y = 0;
      errors = 0;
      checked = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [31:0] value);
      case (idx)
        CFG_PIVOT_X:  pivot_x = longint'($signed(value));
        CFG_PIVOT_Y:  pivot_y = longint'($signed(value));
        CFG_SCALE:    scale = longint'(value[ScaleW-1:0]);
        CFG_OFFSET_X: offset_x = longint'($signed(value));
        CFG_OFFSET_Y: offset_y = longint'($signed(value));
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint place(longint v, longint piv, longint off);
      longint t;
      t = ((clamp32(v) - piv) * scale + 32768) >>> 16;
      return clamp32(t + piv + off);
    endfunction

    function longint unsigned root(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function void note_prim(prim_t p);
      longint cx[4], cy[4];
      longint ax, ay, bx, by, hw, dx, dy, px, py, v;
      longint unsigned mx, my, len, mpx, mpy;
      quad_t q;
      ax = p.p0_x; ay = p.p0_y; bx = p.p1_x; by = p.p1_y;
      hw = longint'(p.half_width);
      q.out_color = p.color;
      q.out_sprite = p.sprite_index;
      kind_seen[p.action]++;
      case (action_e'(p.action))
        ACT_QUAD: begin
          cx[0] = ax; cy[0] = ay; cx[1] = bx; cy[1] = by;
          cx[2] = p.p2_x; cy[2] = p.p2_y; cx[3] = p.p3_x; cy[3] = p.p3_y;
        end
        ACT_SPRITE: begin
          cx[0] = ax; cy[0] = ay; cx[1] = ax; cy[1] = ay + by;
          cx[2] = ax + bx; cy[2] = ay + by; cx[3] = ax + bx; cy[3] = ay;
        end
        ACT_RECT: begin
          cx[0] = ax; cy[0] = ay + by; cx[1] = ax + bx; cy[1] = ay + by;
          cx[2] = ax + bx; cy[2] = ay; cx[3] = ax; cy[3] = ay;
        end
        default: begin
          q.out_sprite = '0;
          dx = bx - ax;
          dy = by - ay;
          if (dx == 0 && dy == 0) begin
            cx[0] = ax - hw; cy[0] = ay + hw; cx[1] = ax + hw; cy[1] = ay + hw;
            cx[2] = ax + hw; cy[2] = ay - hw; cx[3] = ax - hw; cy[3] = ay - hw;
          end else begin
            mx = dx < 0 ? -dx : dx;
            my = dy < 0 ? -dy : dy;
            while ((mx > my ? mx : my) >= (64'd1 << 31)) begin
              mx >>= 1;
              my >>= 1;
            end
            while ((mx > my ? mx : my) < (64'd1 << 30)) begin
              mx <<= 1;
              my <<= 1;
            end
            len = root(mx * mx + my * my);
            mpx = (my * longint'(hw) + len / 2) / len;
            mpy = (mx * longint'(hw) + len / 2) / len;
            px = dy > 0 ? -longint'(mpx) : longint'(mpx);
            py = dx < 0 ? -longint'(mpy) : longint'(mpy);
            cx[0] = ax + px; cy[0] = ay + py; cx[1] = bx + px; cy[1] = by + py;
            cx[2] = bx - px; cy[2] = by - py; cx[3] = ax - px; cy[3] = ay - py;
          end
        end
      endcase
      for (int i = 0; i < 4; i++) begin
        v = place(cx[i], pivot_x, offset_x);
        q[303 - 64*i -: 32] = v[31:0];
        v = place(cy[i], pivot_y, offset_y);
        q[271 - 64*i -: 32] = v[31:0];
      end
      pending = {pending, q};
    endfunction

    function void check_quad(quad_t got);
      quad_t want;
      string names[10];
      names = '{"out0_x", "out0_y", "out1_x", "out1_y", "out2_x", "out2_y",
                "out3_x", "out3_y", "out_color", "out_sprite"};
      if (pending.size() == 0) begin
        $display("%0t: unexpected quad word %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      for (int i = 0; i < 9; i++) begin
        if (got[303 - 32*i -: 32] !== want[303 - 32*i -: 32]) begin
          $display("%0t: %s expected %h actual %h", $time, names[i],
                   want[303 - 32*i -: 32], got[303 - 32*i -: 32]);
          errors++;
        end
      end
      if (got.out_sprite !== want.out_sprite) begin
        $display("%0t: %s expected %h actual %h", $time, names[9],
                 want.out_sprite, got.out_sprite);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  ptq_prim_if prim_ch ();
  ptq_quad_if quad_ch ();
  ptq_cfg_if  cfg_ch ();
  quad_scoreboard sb;
  bit no_idle;
  int cfg_writes;

  primitive_to_quad_transform u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .prim_i (prim_ch.sink),
    .quad_o (quad_ch.source),
    .cfg_i  (cfg_ch.sink)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // sink side stalls
  int stall_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quad_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      quad_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      quad_ch.ready <= 1'b1;
      stall_left <= gap_len();
    end
  end

  // output words are taken at the next rising edge when both are high
  always @(negedge clk_i) begin
    if (rst_ni && quad_ch.valid && quad_ch.ready) sb.check_quad(quad_ch.data);
  end

  task automatic send_prim(prim_t w);
    int g;
    bit rdy;
    g = gap_len();
    if (g > 0) begin
      prim_ch.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    prim_ch.valid <= 1'b1;
    prim_ch.data <= w;
    forever begin
      @(negedge clk_i);
      rdy = prim_ch.ready;
      @(posedge clk_i);
      if (rdy) break;
    end
    sb.note_prim(w);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] value);
    bit rdy;
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= '{index: idx, value: value};
    forever begin
      @(negedge clk_i);
      rdy = cfg_ch.ready;
      @(posedge clk_i);
      if (rdy) break;
    end
    sb.set_reg(idx, value);
    cfg_writes++;
  endtask

  task automatic drain();
    prim_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic load_regs(logic [31:0] px, logic [31:0] py, logic [31:0] sc,
                           logic [31:0] ox, logic [31:0] oy);
    drain();
    write_reg(CFG_PIVOT_X, px);
    write_reg(CFG_PIVOT_Y, py);
    write_reg(CFG_SCALE, sc);
    write_reg(CFG_OFFSET_X, ox);
    write_reg(CFG_OFFSET_Y, oy);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic coord_t pick_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return coord_t'($signed($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000);
      2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return coord_t'($signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000);
    endcase
  endfunction

  function automatic prim_t make_prim(action_e act, coord_t ax, coord_t ay,
                                     coord_t bx, coord_t by, logic [HwW-1:0] hw);
    prim_t p;
    p.action = act;
    p.p0_x = ax; p.p0_y = ay; p.p1_x = bx; p.p1_y = by;
    p.p2_x = $urandom; p.p2_y = $urandom; p.p3_x = $urandom; p.p3_y = $urandom;
    p.half_width = hw;
    p.color = $urandom;
    p.sprite_index = $urandom;
    return p;
  endfunction

  function automatic prim_t rand_prim();
    prim_t p;
    coord_t ax, ay;
    logic [HwW-1:0] hw;
    ax = pick_coord();
    ay = pick_coord();
    hw = $urandom_range(0, 3) == 0 ? HwW'($urandom) : HwW'($urandom_range(0, 32'h40_0000));
    p = make_prim(action_e'($urandom_range(0, 3)), ax, ay, pick_coord(), pick_coord(), hw);
    if (p.action == ACT_LINE) begin
      case ($urandom_range(0, 7))
        0: begin p.p1_x = ax; p.p1_y = ay; end
        1: p.p1_x = ax;
        2: p.p1_y = ay;
        3: begin
          p.p1_x = ax + $signed($urandom_range(0, 8)) - 4;
          p.p1_y = ay + $signed($urandom_range(0, 8)) - 4;
        end
        default: ;
      endcase
    end
    if (p.action == ACT_QUAD) begin
      p.p2_x = pick_coord(); p.p2_y = pick_coord();
      p.p3_x = pick_coord(); p.p3_y = pick_coord();
    end
    return p;
  endfunction

  localparam coord_t CMax = 32'sh7FFF_FFFF;
  localparam coord_t CMin = 32'sh8000_0000;
  localparam logic [HwW-1:0] HwMax = '1;

  initial begin
    prim_t p;
    sb = new();
    no_idle = 1'b0;
    cfg_writes = 0;
    rst_ni = 1'b0;
    prim_ch.valid = 1'b0;
    prim_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words under reset registers
    p = make_prim(ACT_QUAD, CMax, CMax, CMax, CMax, '0);
    p.p2_x = CMax; p.p2_y = CMax; p.p3_x = CMax; p.p3_y = CMax; p.color = '1; p.sprite_index = '1;
    send_prim(p);
    p = make_prim(ACT_QUAD, CMin, CMin, CMin, CMin, '0);
    p.p2_x = CMin; p.p2_y = CMin; p.p3_x = CMin; p.p3_y = CMin; p.color = '0; p.sprite_index = '0;
    send_prim(p);
    send_prim(make_prim(ACT_SPRITE, 32'sh0001_0000, 32'sh0002_0000, 32'sh0010_0000, 32'sh0008_0000, '0));
    send_prim(make_prim(ACT_SPRITE, CMax, CMax, CMax, CMax, HwMax));
    send_prim(make_prim(ACT_SPRITE, CMin, CMin, CMin, CMin, '0));
    send_prim(make_prim(ACT_RECT, 32'sh0001_0000, 32'sh0002_0000, 32'sh0010_0000, 32'sh0008_0000, '0));
    send_prim(make_prim(ACT_RECT, CMax, CMin, CMax, CMin, '0));
    send_prim(make_prim(ACT_LINE, 32'sh0005_0000, 32'sh0005_0000, 32'sh0005_0000, 32'sh0005_0000, 31'h0002_0000));
    send_prim(make_prim(ACT_LINE, CMax, CMin, CMax, CMin, HwMax));
    send_prim(make_prim(ACT_LINE, 0, 0, 32'sh0010_0000, 0, 31'h0001_0000));
    send_prim(make_prim(ACT_LINE, 0, 0, 0, 32'sh0010_0000, 31'h0001_0000));
    send_prim(make_prim(ACT_LINE, 0, 0, -32'sh0010_0000, -32'sh0010_0000, 31'h0001_8000));
    send_prim(make_prim(ACT_LINE, CMin, CMin, CMax, CMax, HwMax));
    send_prim(make_prim(ACT_LINE, CMax, CMin, CMin, CMax, 31'h0000_0001));
    send_prim(make_prim(ACT_LINE, 0, 0, 1, 0, '0));
    send_prim(make_prim(ACT_LINE, 0, 0, 1, -1, HwMax));

    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: load_regs(0, 0, 32'h0001_0000, 0, 0);
        1: load_regs(CMin, CMax, 32'hFFFF_FFFF, CMax, CMin);
        2: load_regs(CMax, CMin, 0, CMin, CMax);
        3: load_regs($urandom, $urandom, $urandom, $urandom, $urandom);
        4: load_regs(pick_coord(), pick_coord(), $urandom_range(32'h8000, 32'h2_0000),
                     pick_coord(), pick_coord());
        5: load_regs(32'sh0010_0000, -32'sh0010_0000, 32'h0000_8000, 32'sh0100_0000, 0);
        default: load_regs($urandom, $urandom, $urandom_range(0, 32'h4_0000), $urandom, $urandom);
      endcase
      no_idle = (phase == 3);
      for (int n = 0; n < 85; n++) send_prim(rand_prim());
    end
    no_idle = 1'b0;
    drain();

    $display("covered %0d quads (quad %0d, sprite %0d, rect %0d, line %0d), %0d register writes",
             sb.checked, sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2], sb.kind_seen[3],
             cfg_writes);
    $display("register settings included scale zero, maximum scale and extreme pivots and offsets");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Test completed with failures");
    $finish;
  end
endmodule
